>>> design/sse_data_event_deframer_macros.svh
// ----------------------------------------------------------------------------
// SSE deframer assertion macros
// Shared property forms for the checker, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SSE_DATA_EVENT_DEFRAMER_MACROS_SVH
`define SSE_DATA_EVENT_DEFRAMER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SSE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sse_pkg.sv
// ----------------------------------------------------------------------------
// SSE deframer package
// Result kinds, framing characters and tag lookup shared by the design files.
// ----------------------------------------------------------------------------
package sse_pkg;

	// result kinds on the output channel
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// framing characters
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// lengths of the "data:" line tag and the "[DONE]" sentinel
	localparam logic [2:0] TAG_LEN  = 3'd5;
	localparam logic [2:0] SENT_LEN = 3'd6;

	// one result run: held sentinel bytes first, then an optional tail result
	typedef struct packed {
		logic [2:0] flush_cnt;
		logic       tail_valid;
		logic [1:0] tail_kind;
		logic [7:0] tail_byte;
	} run_t;

	// characters of "data:"
	function automatic logic [7:0] data_tag_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h64;
			3'd1: c = 8'h61;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			3'd4: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// characters of "[DONE]"
	function automatic logic [7:0] done_tag_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h5B;
			3'd1: c = 8'h44;
			3'd2: c = 8'h4F;
			3'd3: c = 8'h4E;
			3'd4: c = 8'h45;
			3'd5: c = 8'h5D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> design/sse_byte_if.sv
// ----------------------------------------------------------------------------
// SSE byte channel
// Valid/ready channel carrying one raw stream byte per beat.
// ----------------------------------------------------------------------------
interface sse_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

>>> design/sse_result_if.sv
// ----------------------------------------------------------------------------
// SSE result channel
// Valid/ready channel carrying one deframer result per beat.
// ----------------------------------------------------------------------------
interface sse_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_kind, output out_byte, output last_of_run,
		input ready);
	modport sink (input valid, input out_kind, input out_byte, input last_of_run,
		output ready);
endinterface

>>> design/sse_data_event_deframer.sv
// ----------------------------------------------------------------------------
// SSE data event deframer
// Splits a raw server-sent-events byte stream into events and streams out
// the joined data payload of each event that has data, followed by an end marker or a done
// result when the payload is exactly the "[DONE]" sentinel.
//
//   channel  dir  beat payload
//   in_ch    in   in_byte (raw stream byte)
//   out_ch   out  out_kind, out_byte, last_of_run (one result)
//
// An accepted byte is registered in the input stage, then decoded into a run
// of up to seven results held in the run register once that register is
// free; the run register offers its results on out_ch. Bytes are taken one
// per cycle as long as each yields at most one result and the output does
// not stall; a byte yielding more results holds input off while the run
// register drains one result per output beat.
// Reset clears all parse state and drops any unfinished event.
// ----------------------------------------------------------------------------
module sse_data_event_deframer (
	input  logic         clk,
	input  logic         arst_n,
	sse_byte_if.sink     in_ch,
	sse_result_if.source out_ch
);
	import sse_pkg::*;

	typedef enum logic [2:0] {
		TRK_NONE,
		TRK_LF,
		TRK_CR,
		TRK_CRLF,
		TRK_CRLFCR
	} trk_t;

	typedef enum logic [1:0] {
		CLS_UNDECIDED,
		CLS_DATA,
		CLS_SKIP
	} cls_t;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state
	trk_t       trk_q;
	logic [2:0] pos_q;
	cls_t       cls_q;
	logic       strip_q;
	logic       has_data_q;
	logic [2:0] match_q;
	logic       poss_q;

	// run register
	run_t       run_q;
	logic       run_valid_q;
	logic [2:0] idx_q;

	// next-state and run decode
	trk_t       nxt_trk;
	logic [2:0] nxt_pos;
	cls_t       nxt_cls;
	logic       nxt_strip;
	logic       nxt_has_data;
	logic [2:0] nxt_match;
	logic       nxt_poss;
	run_t       nxt_run;
	logic       pl_valid;
	logic [7:0] pl_char;

	logic at_tail;
	logic run_done;
	logic run_free;
	logic fire;

	// output side: held sentinel bytes, then the tail result
	assign at_tail            = (idx_q == run_q.flush_cnt);
	assign out_ch.valid       = run_valid_q;
	assign out_ch.out_kind    = at_tail ? run_q.tail_kind : KIND_DATA;
	assign out_ch.out_byte    = at_tail ? run_q.tail_byte : done_tag_char(idx_q);
	assign out_ch.last_of_run = at_tail ||
		(!run_q.tail_valid && ((idx_q + 3'd1) == run_q.flush_cnt));

	// handshake between the input stage and the run register
	assign run_done    = run_valid_q && out_ch.ready && out_ch.last_of_run;
	assign run_free    = !run_valid_q || run_done;
	assign fire        = valid_s1 && run_free;
	assign in_ch.ready = !valid_s1 || run_free;

	// per-byte parse step
	always_comb begin
		nxt_trk      = trk_q;
		nxt_pos      = pos_q;
		nxt_cls      = cls_q;
		nxt_strip    = strip_q;
		nxt_has_data = has_data_q;
		nxt_match    = match_q;
		nxt_poss     = poss_q;
		nxt_run      = '0;
		pl_valid     = 1'b0;
		pl_char      = byte_s1;

		if (byte_s1 == CH_LF) begin
			if (trk_q == TRK_LF || trk_q == TRK_CRLF || trk_q == TRK_CRLFCR) begin
				// event boundary
				if (has_data_q) begin
					nxt_run.tail_valid = 1'b1;
					if (poss_q && match_q == SENT_LEN) begin
						nxt_run.tail_kind = KIND_DONE;
					end else begin
						nxt_run.tail_kind = KIND_END;
						if (poss_q) begin
							nxt_run.flush_cnt = match_q;
						end
					end
				end
				nxt_trk      = TRK_NONE;
				nxt_pos      = '0;
				nxt_cls      = CLS_UNDECIDED;
				nxt_strip    = 1'b0;
				nxt_has_data = 1'b0;
				nxt_match    = '0;
				nxt_poss     = 1'b1;
			end else if (trk_q == TRK_CR) begin
				nxt_trk = TRK_CRLF;
			end else begin
				nxt_trk   = TRK_LF;
				nxt_pos   = '0;
				nxt_cls   = CLS_UNDECIDED;
				nxt_strip = 1'b0;
			end
		end else if (byte_s1 == CH_CR) begin
			nxt_trk   = (trk_q == TRK_CRLF) ? TRK_CRLFCR : TRK_CR;
			nxt_pos   = '0;
			nxt_cls   = CLS_UNDECIDED;
			nxt_strip = 1'b0;
		end else begin
			// ordinary line content
			nxt_trk = TRK_NONE;
			case (cls_q)
				CLS_UNDECIDED: begin
					if (pos_q < TAG_LEN && byte_s1 == data_tag_char(pos_q)) begin
						nxt_pos = pos_q + 3'd1;
						if (nxt_pos == TAG_LEN) begin
							nxt_cls      = CLS_DATA;
							nxt_strip    = 1'b1;
							nxt_has_data = 1'b1;
							// joining LF between data lines
							pl_valid     = has_data_q;
							pl_char      = CH_LF;
						end
					end else begin
						nxt_cls = CLS_SKIP;
					end
				end
				CLS_DATA: begin
					nxt_strip = 1'b0;
					pl_valid  = !(strip_q && byte_s1 == CH_SPACE);
				end
				default: begin
				end
			endcase
		end

		// sentinel holder on payload bytes
		if (pl_valid) begin
			if (poss_q && match_q < SENT_LEN && pl_char == done_tag_char(match_q)) begin
				nxt_match = match_q + 3'd1;
			end else begin
				nxt_run.tail_valid = 1'b1;
				nxt_run.tail_kind  = KIND_DATA;
				nxt_run.tail_byte  = pl_char;
				if (poss_q) begin
					nxt_run.flush_cnt = match_q;
					nxt_match         = '0;
					nxt_poss          = 1'b0;
				end
			end
		end
	end

	// input stage and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			trk_q      <= TRK_NONE;
			pos_q      <= '0;
			cls_q      <= CLS_UNDECIDED;
			strip_q    <= 1'b0;
			has_data_q <= 1'b0;
			match_q    <= '0;
			poss_q     <= 1'b1;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (fire) begin
				trk_q      <= nxt_trk;
				pos_q      <= nxt_pos;
				cls_q      <= nxt_cls;
				strip_q    <= nxt_strip;
				has_data_q <= nxt_has_data;
				match_q    <= nxt_match;
				poss_q     <= nxt_poss;
			end
		end
	end

	// run register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (fire) begin
				run_valid_q <= nxt_run.tail_valid || (nxt_run.flush_cnt != 3'd0);
				idx_q       <= '0;
			end else if (run_valid_q && out_ch.ready) begin
				if (out_ch.last_of_run) begin
					run_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
		end
		if (fire) begin
			run_q <= nxt_run;
		end
	end

endmodule

>>> design/sse_checker.sv
// ----------------------------------------------------------------------------
// SSE deframer port checker
// Watches the result channel of the deframer for malformed or unstable beats.
// ----------------------------------------------------------------------------
`include "sse_data_event_deframer_macros.svh"

module sse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic       out_last
);
	import sse_pkg::*;

	// only the three result kinds appear
	`SSE_ASSERT_SAME(a_kind_legal, out_valid, out_kind == KIND_DATA || out_kind == KIND_END || out_kind == KIND_DONE, "illegal result kind")

	// end and done beats carry a zero byte
	`SSE_ASSERT_SAME(a_marker_zero, out_valid && out_kind != KIND_DATA, out_byte == 8'h00, "marker beat with nonzero byte")

	// end and done beats close their run
	`SSE_ASSERT_SAME(a_marker_last, out_valid && out_kind != KIND_DATA, out_last, "marker beat not last of run")

	// a stalled beat holds
	`SSE_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_last), "stalled result beat changed")

endmodule

bind sse_data_event_deframer sse_checker u_sse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_kind  (out_ch.out_kind),
	.out_byte  (out_ch.out_byte),
	.out_last  (out_ch.last_of_run)
);
